@@ rtl/core/lptc_pkg.sv @@
package lptc_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned DIST_W       = 16;
  localparam int unsigned ANGLE_W      = 16;
  localparam int unsigned TRIG_W       = 32;
  localparam int unsigned PHASE_W      = 32;
  localparam int unsigned POS_W        = 24;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned PPB_W        = 11;
  localparam int unsigned MAX_BATCH_DEF = 1024;

  localparam logic [PPB_W-1:0]          PPB_RESET       = 11'd100;
  localparam logic signed [TRIG_W-1:0]  CORDIC_GAIN_Q30 = 32'sd652032874;

  // arctangent of 2^-i in centidegrees * 2^16
  localparam logic signed [PHASE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
    32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
    32'sd1466765,   32'sd733385,    32'sd366694,   32'sd183347,
    32'sd91674,     32'sd45837,     32'sd22918,    32'sd11459,
    32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
    32'sd358,       32'sd179,       32'sd89,       32'sd45
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0]  x;
    logic signed [TRIG_W-1:0]  y;
    logic signed [PHASE_W-1:0] z;
    logic signed [DIST_W-1:0]  dist_cm;
    logic                      neg;
    logic [IDX_W-1:0]          idx;
    logic                      last;
  } cdata_t;

endpackage

@@ rtl/core/lptc_batch_ctr.sv @@
module lptc_batch_ctr #(
  parameter int unsigned MAX_BATCH = lptc_pkg::MAX_BATCH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lptc_pkg::PPB_W-1:0]    cfg_data,
  input  logic                          take,
  output logic [lptc_pkg::IDX_W-1:0]    idx,
  output logic                          last
);

  localparam int unsigned PPB_MAX = (1 << lptc_pkg::PPB_W) - 1;
  localparam int unsigned CLIP    = (MAX_BATCH > PPB_MAX) ? PPB_MAX : MAX_BATCH;
  localparam logic [lptc_pkg::PPB_W-1:0] CLIP_V = CLIP[lptc_pkg::PPB_W-1:0];

  logic [lptc_pkg::PPB_W-1:0] ppb_r;
  logic [lptc_pkg::IDX_W-1:0] count_r;
  logic [lptc_pkg::IDX_W-1:0] count_nxt;
  logic [lptc_pkg::PPB_W-1:0] size;
  logic [lptc_pkg::PPB_W-1:0] count_inc;

  always_comb begin
    size = ppb_r;
    if (size == '0) begin
      size = {{(lptc_pkg::PPB_W-1){1'b0}}, 1'b1};
    end
    if (size > CLIP_V) begin
      size = CLIP_V;
    end
  end

  assign count_inc = {{(lptc_pkg::PPB_W-lptc_pkg::IDX_W){1'b0}}, count_r}
                     + {{(lptc_pkg::PPB_W-1){1'b0}}, 1'b1};
  assign last      = (count_inc >= size);
  assign idx       = count_r;
  assign count_nxt = last ? '0 : count_inc[lptc_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppb_r   <= lptc_pkg::PPB_RESET;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        ppb_r <= cfg_data;
      end
      if (take) begin
        count_r <= count_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take && !cfg_we |=> $stable(count_r))
    else $error("point counter moved without a transfer");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    take && last |=> count_r == '0)
    else $error("point counter did not wrap after batch end");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && !last |=> count_r == $past(count_r) + 1'b1)
    else $error("point counter did not advance by one");
`endif

endmodule

@@ rtl/core/lptc_cordic_stage.sv @@
module lptc_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lptc_pkg::cdata_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lptc_pkg::cdata_t out_data
);

  localparam logic signed [lptc_pkg::PHASE_W-1:0] ATAN = lptc_pkg::ATAN_TAB[STEP];

  logic             valid_r;
  lptc_pkg::cdata_t data_r;
  lptc_pkg::cdata_t data_nxt;
  logic signed [lptc_pkg::TRIG_W-1:0] dx;
  logic signed [lptc_pkg::TRIG_W-1:0] dy;

  // arithmetic shifts floor toward minus infinity
  assign dx = in_data.y >>> STEP;
  assign dy = in_data.x >>> STEP;

  always_comb begin
    data_nxt = in_data;
    if (!in_data.z[lptc_pkg::PHASE_W-1]) begin
      data_nxt.x = in_data.x - dx;
      data_nxt.y = in_data.y + dy;
      data_nxt.z = in_data.z - ATAN;
    end else begin
      data_nxt.x = in_data.x + dx;
      data_nxt.y = in_data.y - dy;
      data_nxt.z = in_data.z + ATAN;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ rtl/core/lptc_scale.sv @@
module lptc_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lptc_pkg::cdata_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lptc_pkg::POS_W-1:0] out_x_pos,
  output logic signed [lptc_pkg::POS_W-1:0] out_y_pos,
  output logic [lptc_pkg::IDX_W-1:0]        out_point_index,
  output logic                              out_batch_last
);

  localparam int unsigned PROD_W = lptc_pkg::DIST_W + lptc_pkg::TRIG_W;
  localparam int unsigned T_W    = PROD_W + 1;
  localparam int unsigned SH     = 22;
  localparam int unsigned R_W    = T_W - SH;
  localparam logic signed [R_W-1:0] POS_HI = (R_W)'(2**(lptc_pkg::POS_W-1) - 1);
  localparam logic signed [R_W-1:0] POS_LO = -(R_W)'(2**(lptc_pkg::POS_W-1));
  localparam logic signed [T_W-1:0] HALF   = (T_W)'(2**(SH-1));

  // product stage
  logic                        a_valid_r;
  logic signed [PROD_W-1:0]    ps_r;
  logic signed [PROD_W-1:0]    pc_r;
  logic                        neg_r;
  logic [lptc_pkg::IDX_W-1:0]  idx_r;
  logic                        last_r;
  logic                        b_ready;

  // output stage
  logic                        out_valid_r;
  logic signed [T_W-1:0]       ts;
  logic signed [T_W-1:0]       tc;
  logic signed [R_W-1:0]       rs;
  logic signed [R_W-1:0]       rc;
  logic signed [lptc_pkg::POS_W-1:0] xs;
  logic signed [lptc_pkg::POS_W-1:0] yc;

  assign in_ready = !a_valid_r || b_ready;
  assign b_ready  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ps_r   <= PROD_W'(in_data.dist_cm) * PROD_W'(in_data.y);
      pc_r   <= PROD_W'(in_data.dist_cm) * PROD_W'(in_data.x);
      neg_r  <= in_data.neg;
      idx_r  <= in_data.idx;
      last_r <= in_data.last;
    end
  end

  // coordinate is -(d * trig), the fold sign cancels that negation
  always_comb begin
    ts = neg_r ? T_W'(ps_r) : -T_W'(ps_r);
    tc = neg_r ? T_W'(pc_r) : -T_W'(pc_r);
    rs = R_W'((ts + HALF) >>> SH);
    rc = R_W'((tc + HALF) >>> SH);
    if (rs > POS_HI) begin
      xs = POS_HI[lptc_pkg::POS_W-1:0];
    end else if (rs < POS_LO) begin
      xs = POS_LO[lptc_pkg::POS_W-1:0];
    end else begin
      xs = rs[lptc_pkg::POS_W-1:0];
    end
    if (rc > POS_HI) begin
      yc = POS_HI[lptc_pkg::POS_W-1:0];
    end else if (rc < POS_LO) begin
      yc = POS_LO[lptc_pkg::POS_W-1:0];
    end else begin
      yc = rc[lptc_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_ready) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      out_x_pos       <= xs;
      out_y_pos       <= yc;
      out_point_index <= idx_r;
      out_batch_last  <= last_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_ready |=> a_valid_r && $stable(ps_r) && $stable(pc_r))
    else $error("product stage lost data while the output was held");
`endif

endmodule

@@ rtl/core/lidar_polar_to_cartesian_batcher.sv @@
// pipeline: an input transfer passes the front register, 24 cordic iteration
//   stages, the product stage and the output register before the result is valid
// throughput: one sample per cycle; each cordic iteration has its own stage
// stalls back-pressure stage by stage, empty stages keep filling
// reset: synchronous active-low rst_n clears all valid flags and the point
//   counter, points_per_batch returns to 100
module lidar_polar_to_cartesian_batcher #(
  parameter int unsigned MAX_BATCH = lptc_pkg::MAX_BATCH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [lptc_pkg::DIST_W-1:0]   in_distance_cm,
  input  logic signed [lptc_pkg::ANGLE_W-1:0]  in_angle_centideg,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lptc_pkg::POS_W-1:0]    out_x_pos,
  output logic signed [lptc_pkg::POS_W-1:0]    out_y_pos,
  output logic [lptc_pkg::IDX_W-1:0]           out_point_index,
  output logic                                 out_batch_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lptc_pkg::PPB_W-1:0]           cfg_points_per_batch
);

  localparam int unsigned N = lptc_pkg::CORDIC_STEPS;
  localparam int unsigned A_W = lptc_pkg::ANGLE_W + 1;

  logic                       take;
  logic [lptc_pkg::IDX_W-1:0] idx;
  logic                       last;
  logic signed [A_W-1:0]      a_wrap;
  logic signed [A_W-1:0]      a_fold;
  logic                       neg;
  lptc_pkg::cdata_t           front_nxt;

  logic [N:0]       cv;
  logic [N:0]       cr;
  lptc_pkg::cdata_t cd [N+1];

  logic             front_valid_r;
  lptc_pkg::cdata_t front_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = front_valid_r && !cr[0];
  assign take      = in_valid && !in_stall;

  lptc_batch_ctr #(
    .MAX_BATCH (MAX_BATCH)
  ) u_batch (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_points_per_batch),
    .take     (take),
    .idx      (idx),
    .last     (last)
  );

  // wrap into [-18000, 18000), then fold into [-9000, 9000]
  always_comb begin
    a_wrap = A_W'(in_angle_centideg);
    if (a_wrap >= 17'sd18000) begin
      a_wrap = a_wrap - 17'sd36000;
    end else if (a_wrap < -17'sd18000) begin
      a_wrap = a_wrap + 17'sd36000;
    end
    a_fold = a_wrap;
    neg    = 1'b0;
    if (a_wrap > 17'sd9000) begin
      a_fold = a_wrap - 17'sd18000;
      neg    = 1'b1;
    end else if (a_wrap < -17'sd9000) begin
      a_fold = a_wrap + 17'sd18000;
      neg    = 1'b1;
    end
    front_nxt.x       = lptc_pkg::CORDIC_GAIN_Q30;
    front_nxt.y       = '0;
    front_nxt.z       = {a_fold[lptc_pkg::PHASE_W-17:0], 16'h0000};
    front_nxt.dist_cm = in_distance_cm;
    front_nxt.neg     = neg;
    front_nxt.idx     = idx;
    front_nxt.last    = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (!in_stall) begin
      front_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      front_r <= front_nxt;
    end
  end

  assign cv[0] = front_valid_r;
  assign cd[0] = front_r;

  for (genvar i = 0; i < N; i++) begin : g_cordic
    lptc_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cd[i+1])
    );
  end

  lptc_scale u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (cv[N]),
    .in_ready        (cr[N]),
    .in_data         (cd[N]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_pos       (out_x_pos),
    .out_y_pos       (out_y_pos),
    .out_point_index (out_point_index),
    .out_batch_last  (out_batch_last)
  );

`ifndef SYNTHESIS
  a_front_fill: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> front_valid_r)
    else $error("accepted sample did not reach the front register");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

class cartesian_scoreboard;
  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [9:0]         idx;
    logic               last;
  } point_t;

  localparam int BATCH_CAP = 1024;
  localparam longint UNIT_GAIN = 64'sd652032874;

  point_t      pending_points[$];
  int unsigned batch_size;
  logic [9:0]  point_count;
  int          errors;
  longint      atan_cd[24];

  function new();
    batch_size  = 100;
    point_count = '0;
    errors      = 0;
    // arctan(2^-i) in centidegrees scaled by 2^16
    atan_cd = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
                5866610, 2933484, 1466765, 733385, 366694, 183347,
                91674, 45837, 22918, 11459, 5730, 2865,
                1432, 716, 358, 179, 89, 45};
  endfunction

  function void set_batch_size(logic [10:0] value);
    batch_size = value;
  endfunction

  function void sin_cos(int angle, output longint s, output longint c);
    bit     flip;
    longint x, y, z, dx, dy;
    flip  = 0;
    angle = angle % 36000;
    if (angle < 0) angle += 36000;
    if (angle >= 18000) angle -= 36000;
    // fold into +-90 degrees and negate both results
    if (angle > 9000) begin
      angle -= 18000;
      flip = 1;
    end else if (angle < -9000) begin
      angle += 18000;
      flip = 1;
    end
    x = UNIT_GAIN;
    y = 0;
    z = longint'(angle) * 65536;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_cd[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_cd[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function logic signed [23:0] to_pos(int dist_cm, longint trig);
    longint t, r;
    t = -(longint'(dist_cm) * trig);
    r = (t + (longint'(1) << 21)) >>> 22;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[23:0];
  endfunction

  function void note_sample(logic signed [15:0] dist_cm, logic signed [15:0] angle);
    point_t p;
    longint s, c;
    int     n;
    sin_cos(int'(angle), s, c);
    p.x = to_pos(int'(dist_cm), s);
    p.y = to_pos(int'(dist_cm), c);
    n = batch_size;
    if (n < 1) n = 1;
    if (n > BATCH_CAP) n = BATCH_CAP;
    p.idx  = point_count;
    p.last = (int'(point_count) + 1 >= n);
    point_count = p.last ? 10'd0 : point_count + 10'd1;
    pending_points.push_back(p);
  endfunction

  function void check_point(logic signed [23:0] x, logic signed [23:0] y,
                            logic [9:0] idx, logic last);
    point_t e;
    if (pending_points.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected point: x=%0d y=%0d idx=%0d last=%0b", x, y, idx, last);
      return;
    end
    e = pending_points.pop_front();
    if (x !== e.x || y !== e.y || idx !== e.idx || last !== e.last) begin
      errors++;
      if (errors <= 10)
        $display("point mismatch: expected x=%0d y=%0d idx=%0d last=%0b, got x=%0d y=%0d idx=%0d last=%0b",
                 e.x, e.y, e.idx, e.last, x, y, idx, last);
    end
  endfunction
endclass

module testbench;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  logic signed [lptc_pkg::DIST_W-1:0]   in_distance_cm;
  logic signed [lptc_pkg::ANGLE_W-1:0]  in_angle_centideg;
  logic                                 out_valid;
  logic                                 out_stall;
  logic signed [lptc_pkg::POS_W-1:0]    out_x_pos;
  logic signed [lptc_pkg::POS_W-1:0]    out_y_pos;
  logic [lptc_pkg::IDX_W-1:0]           out_point_index;
  logic                                 out_batch_last;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [lptc_pkg::PPB_W-1:0]           cfg_points_per_batch;

  cartesian_scoreboard sb = new();
  int idle_cycles;

  lidar_polar_to_cartesian_batcher DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_distance_cm       (in_distance_cm),
    .in_angle_centideg    (in_angle_centideg),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_x_pos            (out_x_pos),
    .out_y_pos            (out_y_pos),
    .out_point_index      (out_point_index),
    .out_batch_last       (out_batch_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_points_per_batch (cfg_points_per_batch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // both sides sampled at the rising edge, inputs noted before results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_sample(in_distance_cm, in_angle_centideg);
      if (out_valid && !out_stall)
        sb.check_point(out_x_pos, out_y_pos, out_point_index, out_batch_last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver back-pressure, in a pattern picked anew at random from four modes
  int stall_mode;
  int stall_tick;
  always @(negedge clk) begin
    if (stall_tick % 250 == 0) stall_mode <= $urandom_range(0, 3);
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= (stall_tick % 16) < 10;
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_sample(logic signed [15:0] dist_cm, logic signed [15:0] angle);
    @(negedge clk);
    in_valid          <= 1'b1;
    in_distance_cm    <= dist_cm;
    in_angle_centideg <= angle;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic go_quiet(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_batch_size(logic [10:0] value);
    @(negedge clk);
    cfg_valid            <= 1'b1;
    cfg_points_per_batch <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_batch_size(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_distance();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($urandom_range(0, 200) - 100);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_angle();
    int quadrant;
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: begin
        quadrant = $urandom_range(0, 4);
        return 16'(quadrant * 9000 - 18000);
      end
      default: return 16'($urandom_range(0, 36000) - 18000);
    endcase
  endfunction

  task automatic run_bursts(int count);
    int burst;
    int gap;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > count) burst = count;
      repeat (burst) send_sample(pick_distance(), pick_angle());
      count -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) go_quiet(gap);
    end
    go_quiet(1);
  endtask

  logic signed [15:0] dir_dist[12] = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
                                       16'sd1000, -16'sd1000, 16'sd12345, -16'sd32768,
                                       16'sd32767, 16'sd500, -16'sd32768};
  logic signed [15:0] dir_angle[12] = '{16'sd0, 16'sd9000, -16'sd9000, 16'sd18000,
                                        -16'sd18000, 16'sd9001, -16'sd9001, 16'sd17999,
                                        16'sd32767, -16'sd32768, 16'sd27000, -16'sd27000};

  initial begin
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_distance_cm       = '0;
    in_angle_centideg    = '0;
    out_stall            = 1'b0;
    cfg_valid            = 1'b0;
    cfg_points_per_batch = '0;
    stall_mode           = 0;
    stall_tick           = 1;
    idle_cycles          = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // edge distances and angles at the reset batch size, incl. wrap and clamp
    for (int i = 0; i < 12; i++) send_sample(dir_dist[i], dir_angle[i]);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd32767, 16'sd18000);
    send_sample(-16'sd32768, -16'sd9000);
    go_quiet(1);
    wait_drained();

    write_batch_size(11'd1);
    repeat (4) send_sample(pick_distance(), pick_angle());
    run_bursts(60);
    wait_drained();

    // zero behaves as one
    write_batch_size(11'd0);
    run_bursts(60);
    wait_drained();

    // all ones saturates to the cap
    write_batch_size(11'd2047);
    run_bursts(150);
    wait_drained();

    // lowered below the current count: next transfer closes the batch
    write_batch_size(11'd3);
    run_bursts(80);
    wait_drained();

    write_batch_size(11'd1024);
    run_bursts(1030);
    wait_drained();

    write_batch_size(11'd37);
    run_bursts(150);
    wait_drained();

    write_batch_size(11'd1025);
    run_bursts(120);
    wait_drained();

    write_batch_size(11'd2);
    run_bursts(80);
    wait_drained();

    write_batch_size(11'($urandom_range(4, 90)));
    run_bursts(120);
    wait_drained();

    write_batch_size(11'd100);
    run_bursts(100);
    wait_drained();

    if (sb.errors == 0 && sb.pending_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
